### src/sqe_pkg.sv
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared sizes, command codes, status codes and controller states for the
// stack/queue engine and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sqe_pkg;

   // Store geometry.
   localparam int DEPTH    = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // Field widths.
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int REQ_USER_W = KIND_W + 1;

   // Command codes carried in the request word.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 3'd0,
      KIND_PRINT = 3'd1,
      KIND_PEEK  = 3'd2,
      KIND_POP   = 3'd3,
      KIND_SWAP  = 3'd4
   } kind_type;

   // Status codes carried in the response word.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 3'd0,
      ST_DATA       = 3'd1,
      ST_USAGE      = 3'd2,
      ST_PEEK_EMPTY = 3'd3,
      ST_POP_EMPTY  = 3'd4,
      ST_SWAP_SHORT = 3'd5,
      ST_FULL       = 3'd6
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_RESP,
      S_SWAP_B,
      S_SWAP_W,
      S_PRINT
   } state_type;

endpackage

`default_nettype wire

### src/sqe_ram.sv
// ----------------------------------------------------------------------------
// sqe_ram
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read, read-first on a collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/stack_queue_engine.sv
// Responses: push, pop, peek and every error pass through state S_RESP into the
// registered response word; swap passes through S_SWAP_B and S_SWAP_W first.
// A new request word is taken only in S_IDLE, once the last response word is loaded;
// print-all streams one word per cycle from the one RAM read port unless stalled.
// Reset (synchronous): empties the store and selects stack mode;
// the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// stack_queue_engine
// Bounded store of signed 32-bit integers held as a circular buffer in RAM,
// with push, print-all, peek, pop and swap commands in stack or queue mode.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_queue_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [sqe_pkg::DATA_W-1:0]       req_tdata,  // [31:0] push_value
   input  wire logic [sqe_pkg::REQ_USER_W-1:0]   req_tuser,  // [2:0] kind, [3] value_valid
   // Response channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [sqe_pkg::DATA_W-1:0]       rsp_tdata,  // [31:0] data_out
   output logic      [sqe_pkg::STATUS_W-1:0]     rsp_tuser,  // [2:0] status
   output logic                                  rsp_tlast,
   // Mode register.
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data
);

   import sqe_pkg::*;

   // Index plus count, wrapped once around the buffer.
   function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

   // Registers.
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   status_type          resp_status_ff, resp_status_in;
   logic                resp_from_ram_ff, resp_from_ram_in;
   logic                queue_mode_ff;
   logic                rsp_tvalid_ff;
   logic [DATA_W-1:0]   rsp_tdata_ff;
   logic [STATUS_W-1:0] rsp_tuser_ff;
   logic                rsp_tlast_ff;

   // RAM port signals.
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [DATA_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [DATA_W-1:0]   ram_rd_data;

   // Decode and output-stage signals.
   kind_type            req_kind;
   logic                req_value_valid;
   logic                req_accept;
   status_type          dec_status;
   logic                dec_push, dec_print, dec_silent, dec_peek, dec_pop, dec_swap;
   logic                out_free;
   logic                print_last;
   logic                load_out;
   logic [DATA_W-1:0]   out_data;
   status_type          out_status;
   logic                out_last;

   assign req_kind        = kind_type'(req_tuser[KIND_W-1:0]);
   assign req_value_valid = req_tuser[KIND_W];
   assign req_accept      = req_tvalid & req_tready;
   assign out_free        = ~rsp_tvalid_ff | rsp_tready;
   assign print_last      = (pos_ff + CNT_W'(1)) == count_ff;

   sqe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Command decode against the current fill level.
   always_comb begin
      dec_status = ST_DONE;
      dec_push   = 1'b0;
      dec_print  = 1'b0;
      dec_silent = 1'b0;
      dec_peek   = 1'b0;
      dec_pop    = 1'b0;
      dec_swap   = 1'b0;
      case (req_kind)
         KIND_PUSH: begin
            if (!req_value_valid) begin
               dec_status = ST_USAGE;
            end else if (count_ff >= CNT_W'(DEPTH)) begin
               dec_status = ST_FULL;
            end else begin
               dec_push = 1'b1;
            end
         end
         KIND_PRINT: begin
            if (count_ff == '0) begin
               dec_silent = 1'b1;
            end else begin
               dec_print = 1'b1;
            end
         end
         KIND_PEEK: begin
            if (count_ff == '0) begin
               dec_status = ST_PEEK_EMPTY;
            end else begin
               dec_status = ST_DATA;
               dec_peek   = 1'b1;
            end
         end
         KIND_POP: begin
            if (count_ff == '0) begin
               dec_status = ST_POP_EMPTY;
            end else begin
               dec_pop = 1'b1;
            end
         end
         KIND_SWAP: begin
            if (count_ff < CNT_W'(2)) begin
               dec_status = ST_SWAP_SHORT;
            end else begin
               dec_swap = 1'b1;
            end
         end
         default: begin
            dec_status = ST_USAGE;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (dec_print) begin
                  state_in = S_PRINT;
               end else if (dec_swap) begin
                  state_in = S_SWAP_B;
               end else if (!dec_silent) begin
                  state_in = S_RESP;
               end
            end
         end
         S_SWAP_B: begin
            state_in = S_SWAP_W;
         end
         S_SWAP_W: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_PRINT: begin
            if (out_free && print_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs: handshake, RAM accesses, pointer updates and response loading.
   always_comb begin
      req_tready       = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = front_ff;
      ram_wr_data      = req_tdata;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = front_ff;
      load_out         = 1'b0;
      out_data         = '0;
      out_status       = resp_status_ff;
      out_last         = 1'b1;
      front_in         = front_ff;
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      pos_in           = pos_ff;
      resp_status_in   = resp_status_ff;
      resp_from_ram_in = resp_from_ram_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               resp_status_in   = dec_status;
               resp_from_ram_in = dec_peek;
               // Push goes to the slot behind the last entry, or before the front.
               if (dec_push) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  if (queue_mode_ff) begin
                     ram_wr_addr = idx_add(front_ff, count_ff);
                  end else begin
                     ram_wr_addr = idx_dec(front_ff);
                     front_in    = idx_dec(front_ff);
                  end
               end
               if (dec_pop) begin
                  front_in = idx_inc(front_ff);
                  count_in = count_ff - CNT_W'(1);
               end
               // Peek, print-all and swap all start by reading the front entry.
               if (dec_peek || dec_print || dec_swap) begin
                  ram_rd_en = 1'b1;
                  ptr_in    = idx_inc(front_ff);
                  pos_in    = '0;
               end
            end
         end
         S_SWAP_B: begin
            // The front value moves to the second slot while the old one is read.
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_ff;
         end
         S_SWAP_W: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = front_ff;
            ram_wr_data = ram_rd_data;
         end
         S_RESP: begin
            load_out = out_free;
            out_data = resp_from_ram_ff ? ram_rd_data : '0;
         end
         S_PRINT: begin
            load_out   = out_free;
            out_data   = ram_rd_data;
            out_status = ST_DATA;
            out_last   = print_last;
            if (out_free && !print_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff;
               ptr_in      = idx_inc(ptr_ff);
               pos_in      = pos_ff + CNT_W'(1);
            end
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
   end

   // Control and buffer pointer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         queue_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            queue_mode_ff <= csr_wr_data;
         end
      end
   end

   // Working registers for the command in flight.
   always_ff @(posedge clock) begin
      ptr_ff           <= ptr_in;
      pos_ff           <= pos_in;
      resp_status_ff   <= resp_status_in;
      resp_from_ram_ff <= resp_from_ram_in;
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= out_data;
         rsp_tuser_ff <= out_status;
         rsp_tlast_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

### src/sqe_checker.sv
// ----------------------------------------------------------------------------
// sqe_checker
// Port-level checks on the response channel of the stack/queue engine,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [sqe_pkg::DATA_W-1:0]    rsp_tdata,
   input wire logic [sqe_pkg::STATUS_W-1:0]  rsp_tuser,
   input wire logic                          rsp_tlast
);

   import sqe_pkg::*;

   // No response word is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word offered after reset");

   // A stalled response word holds its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // Only data words carry a value.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DATA) |-> rsp_tdata == '0)
      else $error("non-data response with non-zero value");

   // A status word is always the single, final word of its command.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DATA) |-> rsp_tlast)
      else $error("status response not marked last");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (.*);

`default_nettype wire

### tb/stack_queue_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_tb
// Self-checking testbench for the stack/queue engine. A short table of
// directed commands covers the empty, usage and value extremes after reset.
// Four random phases follow that switch between stack and queue mode and fill
// the store to its limit. Each response word is checked against a shadow copy
// of the store that is kept in step with every accepted request word.
// ----------------------------------------------------------------------------

module stack_queue_engine_tb;

   import sqe_pkg::*;

   // Command codes that the engine does not know.
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 10;
   localparam int DIRECTED_ROWS = 24;
   localparam int PHASE_COUNT = 4;

   // Random phases: mode, number of words and share of pushes in percent.
   localparam logic PHASE_MODE [PHASE_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0};
   localparam int PHASE_WORDS [PHASE_COUNT] = '{80, 55, 55, 55};
   localparam int PHASE_PUSH_PCT [PHASE_COUNT] = '{95, 30, 60, 45};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] value;
      logic              valid;
      logic              typed;
      status_type        typed_status;
   } command_row_type;

   typedef struct packed {
      logic       typed;
      status_type status;
   } fixed_answer_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic              last;
   } rsp_word_type;

   // Directed commands in stack mode straight after reset. Errors carry their
   // status here; the rest is left to the shadow store.
   localparam command_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{KIND_PEEK,  32'h0000_0000, 1'b1, 1'b1, ST_PEEK_EMPTY},
      '{KIND_POP,   32'hFFFF_FFFF, 1'b1, 1'b1, ST_POP_EMPTY},
      '{KIND_SWAP,  32'h5555_AAAA, 1'b0, 1'b1, ST_SWAP_SHORT},
      '{KIND_PRINT, 32'h0000_0001, 1'b1, 1'b0, ST_DONE},
      '{KIND_PUSH,  32'h1234_5678, 1'b0, 1'b1, ST_USAGE},
      '{KIND_UNUSED_LO,  32'hDEAD_BEEF, 1'b1, 1'b1, ST_USAGE},
      '{KIND_UNUSED_MID, 32'h0000_0000, 1'b0, 1'b1, ST_USAGE},
      '{KIND_UNUSED_HI,  32'hFFFF_FFFF, 1'b1, 1'b1, ST_USAGE},
      '{KIND_PUSH,  32'h8000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_SWAP,  32'h0000_0000, 1'b1, 1'b1, ST_SWAP_SHORT},
      '{KIND_PUSH,  32'h7FFF_FFFF, 1'b1, 1'b0, ST_DONE},
      '{KIND_PUSH,  32'h0000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_PUSH,  32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE},
      '{KIND_PEEK,  32'hA5A5_A5A5, 1'b0, 1'b0, ST_DONE},
      '{KIND_SWAP,  32'h0F0F_0F0F, 1'b1, 1'b0, ST_DONE},
      '{KIND_PRINT, 32'h0000_0000, 1'b0, 1'b0, ST_DONE},
      '{KIND_POP,   32'h0000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_PEEK,  32'h0000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_PRINT, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE},
      '{KIND_POP,   32'h0000_0000, 1'b0, 1'b0, ST_DONE},
      '{KIND_POP,   32'h0000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_POP,   32'h0000_0000, 1'b1, 1'b0, ST_DONE},
      '{KIND_POP,   32'h8000_0000, 1'b1, 1'b1, ST_POP_EMPTY},
      '{KIND_PRINT, 32'h7FFF_FFFF, 1'b1, 1'b0, ST_DONE}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_wr_data = 1'b0;

   // Shadow copy of the engine state.
   logic [DATA_W-1:0] mirror_entries [DEPTH];
   int                mirror_front = 0;
   int                mirror_count = 0;
   logic              mirror_queue_mode = 1'b0;

   rsp_word_type     awaited_words [$];
   fixed_answer_type fixed_answers [$];
   int               mismatch_count = 0;
   logic             tx_idle_enable = 1'b1;
   logic             rx_idle_enable = 1'b1;
   logic             hold_request = 1'b0;

   stack_queue_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [31:0] push_value
      .req_tuser   (req_tuser),   // [2:0] kind, [3] value_valid
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [31:0] data_out
      .rsp_tuser   (rsp_tuser),   // [2:0] status
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shadow slot that lies a given number of entries behind the front.
   function automatic logic [IDX_W-1:0] mirror_slot(input int offset);
      return IDX_W'((mirror_front + offset) % DEPTH);
   endfunction

   // Applies one command to the shadow store and, when asked, queues the
   // response words it should give.
   task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                                input logic valid, input logic record);
      rsp_word_type words [$];
      logic [DATA_W-1:0] held;
      logic [IDX_W-1:0]  second;
      case (kind)
         KIND_PUSH: begin
            if (!valid) begin
               words.push_back('{'0, ST_USAGE, 1'b1});
            end else if (mirror_count >= DEPTH) begin
               words.push_back('{'0, ST_FULL, 1'b1});
            end else begin
               if (mirror_queue_mode) begin
                  mirror_entries[mirror_slot(mirror_count)] = value;
               end else begin
                  mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                  mirror_entries[mirror_slot(0)] = value;
               end
               mirror_count++;
               words.push_back('{'0, ST_DONE, 1'b1});
            end
         end
         KIND_PRINT: begin
            for (int i = 0; i < mirror_count; i++)
               words.push_back('{mirror_entries[mirror_slot(i)], ST_DATA,
                                 (i + 1 == mirror_count)});
         end
         KIND_PEEK: begin
            if (mirror_count == 0)
               words.push_back('{'0, ST_PEEK_EMPTY, 1'b1});
            else
               words.push_back('{mirror_entries[mirror_slot(0)], ST_DATA, 1'b1});
         end
         KIND_POP: begin
            if (mirror_count == 0) begin
               words.push_back('{'0, ST_POP_EMPTY, 1'b1});
            end else begin
               mirror_front = (mirror_front + 1) % DEPTH;
               mirror_count--;
               words.push_back('{'0, ST_DONE, 1'b1});
            end
         end
         KIND_SWAP: begin
            if (mirror_count < 2) begin
               words.push_back('{'0, ST_SWAP_SHORT, 1'b1});
            end else begin
               second = mirror_slot(1);
               held = mirror_entries[mirror_slot(0)];
               mirror_entries[mirror_slot(0)] = mirror_entries[second];
               mirror_entries[second] = held;
               words.push_back('{'0, ST_DONE, 1'b1});
            end
         end
         default: begin
            words.push_back('{'0, ST_USAGE, 1'b1});
         end
      endcase
      if (record)
         foreach (words[i]) awaited_words.push_back(words[i]);
   endtask

   task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Checks every response word and updates the shadow store on every
   // accepted request word.
   always @(posedge clock) begin : monitor
      rsp_word_type     want;
      fixed_answer_type fixed;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response word, expected none, actual %h %0d %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = awaited_words.pop_front();
            report_field("data_out", want.data, rsp_tdata);
            report_field("status", DATA_W'(want.status), DATA_W'(rsp_tuser));
            report_field("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
         end
      end
      if (!reset && req_tvalid && req_tready === 1'b1) begin
         fixed = fixed_answers.pop_front();
         apply_command(req_tuser[KIND_W-1:0], req_tdata, req_tuser[KIND_W], !fixed.typed);
         if (fixed.typed)
            awaited_words.push_back('{'0, fixed.status, 1'b1});
      end
   end

   // Ends the run when neither channel moves a word for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Response side: random bursts of stalls, plus one long hold when asked.
   initial begin : receiver
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   // Offers one request word, sometimes after a gap, and waits for it to be
   // taken.
   task automatic send_word(input command_row_type row);
      if (tx_idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      fixed_answers.push_back('{row.typed, row.typed_status});
      req_tvalid <= 1'b1;
      req_tdata  <= row.value;
      req_tuser  <= {row.valid, row.kind};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Writes the mode register once the engine has drained. The first edge
   // lets the monitor book the last accepted request word.
   task automatic set_mode(input logic mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror_queue_mode = mode;
   endtask

   // Values lean towards the signed extremes now and then.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_row(input int push_pct, output command_row_type row);
      int share;
      row.value = pick_value();
      row.valid = 1'b1;
      row.typed = 1'b0;
      row.typed_status = ST_DONE;
      if ($urandom_range(0, 99) < push_pct) begin
         row.kind = KIND_PUSH;
      end else begin
         share = $urandom_range(0, 99);
         row.valid = 1'($urandom_range(0, 1));
         if (share < 12)      row.kind = KIND_PRINT;
         else if (share < 32) row.kind = KIND_PEEK;
         else if (share < 62) row.kind = KIND_POP;
         else if (share < 82) row.kind = KIND_SWAP;
         else if (share < 91) begin
            row.kind = KIND_PUSH;
            row.valid = 1'b0;
         end else begin
            row.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         end
      end
   endtask

   initial begin : stimulus
      command_row_type row;
      foreach (mirror_entries[i]) mirror_entries[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part in the stack mode left by reset.
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(DIRECTED[i]);

      // Random phases, each under its own mode setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_mode(PHASE_MODE[p]);
         for (int n = 0; n < PHASE_WORDS[p]; n++) begin
            if (p == 0 && n == 30)
               hold_request = 1'b1;
            if (p == PHASE_COUNT - 1 && n == 30) begin
               tx_idle_enable = 1'b0;
               rx_idle_enable = 1'b0;
            end
            random_row(PHASE_PUSH_PCT[p], row);
            send_word(row);
         end
      end

      // Drain and let the engine settle before the verdict.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
